// ===== rtl/fixed_partition_allocator_unit_assert.svh =====
// Assertion macros shared by the allocator RTL.
// Every check is clocked on the rising edge and reports through $error.
`ifndef FIXED_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is asserted.
`define FPA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that also holds during reset.
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FPA_ASSERT(lbl, clk, rstn, prop, msg)
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

	// Default sizing of the partition table.
	localparam int MAX_PARTITIONS_DEF = 32;
	localparam int SIZE_BITS_DEF      = 16;

	// Fixed field widths of the channels and the configuration port.
	localparam int SLOT_W     = 5;
	localparam int AMOUNT_W   = 16;
	localparam int LEFT_W     = 16;
	localparam int POLICY_W   = 2;
	localparam int BCOUNT_W   = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	// Item actions.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_ALLOC = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

	// Placement policies; the unused code behaves as first fit.
	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	// Register reset values.
	localparam logic [POLICY_W-1:0] POLICY_RST = POL_FIRST;
	localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 6'd32;

endpackage

`default_nettype wire

// ===== rtl/fpa_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request word: a partition load or an allocate request.
interface fpa_in_if import fpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [SLOT_W-1:0]   slot;
	logic [AMOUNT_W-1:0] amount;

	modport source (output valid, output action, output slot, output amount, input ready);
	modport sink   (input valid, input action, input slot, input amount, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpa_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Response word: outcome of one allocate request.
interface fpa_out_if import fpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              granted;
	logic [SLOT_W-1:0] slot_taken;
	logic [LEFT_W-1:0] leftover;

	modport source (output valid, output granted, output slot_taken, output leftover,
		input ready);
	modport sink   (input valid, input granted, input slot_taken, input leftover,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/fixed_partition_allocator_unit.sv =====
// Channel   Dir  Word fields                     Handshake
// req       in   action, slot, amount            req.valid & req.ready
// rsp       out  granted, slot_taken, leftover   rsp.valid & rsp.ready
// cfg       in   cfg_index, cfg_data             cfg_we
//
// A load is written into the partition RAM when it is accepted. An allocate holds
// the unit busy from its acceptance: the first limit entries, where limit is
// block_count capped at MAX_PARTITIONS, are swept through the single read port of
// the partition RAM one entry per cycle, the last read word is taken, the read
// pipeline is found empty and the used flag is written back. With a zero count only
// the write-back remains. Reset clears every register but not the partition RAM;
// every partition must be loaded before it is scanned. A waiting response stalls
// the unit only at the write-back of the next allocate; loads pass meanwhile.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_partition_allocator_unit_assert.svh"

module fixed_partition_allocator_unit import fpa_pkg::*; #(
	parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
	parameter int SIZE_BITS      = SIZE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fpa_in_if.sink                     req,
	fpa_out_if.source                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_PARTITIONS);
	localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
	localparam int ENT_W = SIZE_BITS + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_t;

	state_t                state_q;
	logic [POLICY_W-1:0]   policy_q;
	logic [BCOUNT_W-1:0]   block_count_q;
	logic [SIZE_BITS-1:0]  amt_q;
	logic [CNT_W-1:0]      limit_q;
	logic [CNT_W-1:0]      iss_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [SIZE_BITS-1:0]  pick_size_q;
	logic [SIZE_BITS-1:0]  key_q;
	logic                  out_valid_q;
	logic                  out_granted_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [LEFT_W-1:0]     out_left_q;

	logic                        req_fire;
	logic                        alloc_fire;
	logic                        wb_grant;
	logic                        out_free;
	logic [SIZE_BITS+AMOUNT_W-1:0] amt_ext;
	logic [SIZE_BITS-1:0]        amt_in;
	logic [IDX_W+SLOT_W-1:0]     slot_ext;
	logic [IDX_W-1:0]            slot_addr;
	logic                        slot_ok;
	logic [CNT_W+BCOUNT_W-1:0]   bc_ext;
	logic [CNT_W-1:0]            limit;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic [ENT_W-1:0]            mem_wdata;
	logic                        mem_re;
	logic [ENT_W-1:0]            mem_rdata;
	logic                        ent_used;
	logic [SIZE_BITS-1:0]        ent_size;
	logic [SIZE_BITS-1:0]        ent_rest;
	logic                        fit;
	logic                        take;
	logic [SIZE_BITS-1:0]        take_key;
	logic [SIZE_BITS-1:0]        pick_rest;
	logic [SLOT_W+IDX_W-1:0]     pick_ext;
	logic [LEFT_W+SIZE_BITS-1:0] rest_ext;

	// Handshakes.
	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign alloc_fire = req_fire && (req.action == ACT_ALLOC);
	assign out_free   = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.granted    = out_granted_q;
	assign rsp.slot_taken = out_slot_q;
	assign rsp.leftover   = out_left_q;

	// Resize the input fields to the table geometry.
	assign amt_ext   = {{SIZE_BITS{1'b0}}, req.amount};
	assign amt_in    = amt_ext[SIZE_BITS-1:0];
	assign slot_ext  = {{IDX_W{1'b0}}, req.slot};
	assign slot_addr = slot_ext[IDX_W-1:0];
	assign slot_ok   = int'(req.slot) < MAX_PARTITIONS;

	// Number of entries to scan, capped at the table depth.
	assign bc_ext = {{CNT_W{1'b0}}, block_count_q};
	always_comb begin
		if (int'(block_count_q) > MAX_PARTITIONS) begin
			limit = CNT_W'(MAX_PARTITIONS);
		end else begin
			limit = bc_ext[CNT_W-1:0];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= POLICY_RST;
			block_count_q <= BCOUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY:      policy_q      <= cfg_data[POLICY_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_data[BCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Partition RAM: the used flag sits above the size.
	assign wb_grant  = (state_q == ST_WRITE) && found_q;
	assign mem_re    = (state_q == ST_SCAN) && (iss_q != limit_q);
	assign mem_we    = (req_fire && req.action == ACT_LOAD && slot_ok) ||
		(wb_grant && out_free);
	assign mem_waddr = (state_q == ST_WRITE) ? pick_q : slot_addr;
	assign mem_wdata = (state_q == ST_WRITE) ? {1'b1, pick_size_q} : {1'b0, amt_in};

	fpa_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_PARTITIONS)
	) u_part_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (iss_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	// Compare the entry that comes back from the RAM against the current pick.
	assign ent_used = mem_rdata[SIZE_BITS];
	assign ent_size = mem_rdata[SIZE_BITS-1:0];
	assign ent_rest = ent_size - amt_q;
	assign fit      = vld_s1 && !ent_used && (ent_size >= amt_q);

	always_comb begin
		unique case (policy_q)
			POL_BEST: begin
				take     = fit && (!found_q || ent_rest < key_q);
				take_key = ent_rest;
			end
			POL_WORST: begin
				take     = fit && (!found_q || ent_size >= key_q);
				take_key = ent_size;
			end
			default: begin
				take     = fit && !found_q;
				take_key = ent_size;
			end
		endcase
	end

	// Result fields of the chosen partition.
	assign pick_rest = pick_size_q - amt_q;
	assign pick_ext  = {{SLOT_W{1'b0}}, pick_q};
	assign rest_ext  = {{LEFT_W{1'b0}}, pick_rest};

	// Sequencer, scan pipeline and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			vld_s1        <= 1'b0;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			iss_q         <= '0;
			limit_q       <= '0;
			amt_q         <= '0;
			idx_s1        <= '0;
			pick_q        <= '0;
			pick_size_q   <= '0;
			key_q         <= '0;
			out_granted_q <= 1'b0;
			out_slot_q    <= '0;
			out_left_q    <= '0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= mem_re;
			idx_s1 <= iss_q[IDX_W-1:0];
			unique case (state_q)
				ST_IDLE: begin
					if (alloc_fire) begin
						amt_q   <= amt_in;
						limit_q <= limit;
						iss_q   <= '0;
						found_q <= 1'b0;
						state_q <= (limit == '0) ? ST_WRITE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						iss_q <= iss_q + 1'b1;
					end
					if (take) begin
						found_q     <= 1'b1;
						pick_q      <= idx_s1;
						pick_size_q <= ent_size;
						key_q       <= take_key;
					end
					if (!mem_re && !vld_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_granted_q <= found_q;
						out_slot_q    <= found_q ? pick_ext[SLOT_W-1:0] : '0;
						out_left_q    <= found_q ? rest_ext[LEFT_W-1:0] : '0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The RAM is never written while a scan is under way.
	`FPA_ASSERT(a_no_write_in_scan, clk, arst_n, (state_q == ST_SCAN) |-> !mem_we, "write during scan")
	// Read data only comes back while scanning.
	`FPA_ASSERT(a_s1_in_scan, clk, arst_n, vld_s1 |-> (state_q == ST_SCAN), "stray read data")
	// An accepted allocate leaves the idle state.
	`FPA_ASSERT(a_alloc_busy, clk, arst_n, alloc_fire |=> state_q != ST_IDLE, "allocate dropped")
	// A chosen partition always covers the request.
	`FPA_ASSERT(a_pick_fits, clk, arst_n, wb_grant |-> pick_size_q >= amt_q, "pick too small")
	// A clock edge inside reset leaves the read pipeline empty.
	`FPA_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> (state_q == ST_IDLE && !vld_s1), "busy in reset")

endmodule

`default_nettype wire

// ===== rtl/fpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module fpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import fpa_pkg::*;

	// The policy code that has no name in the package; it acts as first fit.
	localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;
	// Idle cycles after the last response before a register write or the end.
	localparam int SETTLE_CYCLES = 8;
	// Cycles without any accepted word before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_WORDS = 100;
	localparam int RANDOM_PHASES = 8;

	// One allocate outcome as the response channel carries it.
	typedef struct packed {
		logic              granted;
		logic [SLOT_W-1:0] slot;
		logic [LEFT_W-1:0] left;
	} grant_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fpa_in_if  req_ch ();
	fpa_out_if rsp_ch ();

	fixed_partition_allocator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the partition table and the registers.
	logic [AMOUNT_W-1:0] part_size [MAX_PARTITIONS_DEF];
	bit                  part_used [MAX_PARTITIONS_DEF];
	logic [POLICY_W-1:0] cur_policy;
	logic [BCOUNT_W-1:0] cur_count;

	grant_t grant_queue [$];
	int     mismatches;
	int     quiet_cycles;
	int     ready_hold;
	bit     calm;

	// Clock generation.
	always #1 clk = ~clk;

	// Picks a partition for one request and marks it used, as the block should.
	function automatic grant_t place_request(logic [AMOUNT_W-1:0] need);
		grant_t             g;
		int                 lim;
		int                 pick;
		bit                 found;
		logic [LEFT_W-1:0]  best;
		g = '0;
		pick = 0;
		found = 0;
		best = '0;
		lim = (cur_count > MAX_PARTITIONS_DEF) ? MAX_PARTITIONS_DEF : cur_count;
		for (int i = 0; i < lim; i++) begin
			if (!part_used[i] && part_size[i] >= need) begin
				if (cur_policy == POL_BEST) begin
					if (!found || LEFT_W'(part_size[i] - need) < best) begin
						found = 1;
						pick = i;
						best = part_size[i] - need;
					end
				end else if (cur_policy == POL_WORST) begin
					// Ties go to the higher index, hence the non-strict compare.
					if (!found || part_size[i] >= best) begin
						found = 1;
						pick = i;
						best = part_size[i];
					end
				end else if (!found) begin
					found = 1;
					pick = i;
				end
			end
		end
		if (found) begin
			part_used[pick] = 1;
			g.granted = 1'b1;
			g.slot = pick[SLOT_W-1:0];
			g.left = part_size[pick] - need;
		end
		return g;
	endfunction

	task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
		mismatches++;
		$display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
	endtask

	// Response checking and request prediction, both sampled at the rising edge.
	always @(posedge clk) begin
		grant_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (grant_queue.size() == 0) begin
					mismatches++;
					$display("%0t ns: response word with none expected, actual %0b/%0d/%0d",
						$time, rsp_ch.granted, rsp_ch.slot_taken, rsp_ch.leftover);
				end else begin
					want = grant_queue.pop_front();
					if (rsp_ch.granted !== want.granted)
						flag_mismatch("granted", 32'(want.granted), 32'(rsp_ch.granted));
					if (rsp_ch.slot_taken !== want.slot)
						flag_mismatch("slot_taken", 32'(want.slot), 32'(rsp_ch.slot_taken));
					if (rsp_ch.leftover !== want.left)
						flag_mismatch("leftover", 32'(want.left), 32'(rsp_ch.leftover));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.action == ACT_LOAD) begin
					part_size[req_ch.slot] = req_ch.amount;
					part_used[req_ch.slot] = 0;
				end else begin
					grant_queue.push_back(place_request(req_ch.amount));
				end
			end
		end
	end

	// Watchdog on cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Response back-pressure in random bursts, switched off in the calm part.
	always @(negedge clk) begin
		if (calm) begin
			rsp_ch.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			rsp_ch.ready <= 1'b0;
			ready_hold <= $urandom_range(0, 9);
		end else begin
			rsp_ch.ready <= 1'b1;
			ready_hold <= $urandom_range(0, 15);
		end
	end

	// Sends one request word, with an optional idle gap first; returns at the
	// rising edge where the word is accepted.
	task automatic send_word(logic act, logic [SLOT_W-1:0] slot, logic [AMOUNT_W-1:0] amt);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.slot <= slot;
		req_ch.amount <= amt;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Drops the request channel and waits until every response has arrived.
	task automatic settle_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (grant_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_POLICY)
			cur_policy = data[POLICY_W-1:0];
		else
			cur_count = data[BCOUNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fill the whole table, then allocate under the reset register values.
	task automatic test_defaults();
		for (int i = 0; i < MAX_PARTITIONS_DEF; i++) begin
			if (i == 0)
				send_word(ACT_LOAD, SLOT_W'(i), '0);
			else if (i == MAX_PARTITIONS_DEF - 1)
				send_word(ACT_LOAD, SLOT_W'(i), '1);
			else
				send_word(ACT_LOAD, SLOT_W'(i), AMOUNT_W'($urandom_range(1, 60000)));
		end
		// Only the last partition holds the largest size.
		send_word(ACT_ALLOC, '0, '1);
		send_word(ACT_ALLOC, '0, '0);
		settle_idle();
	endtask

	// Each policy on a four-entry table with ties in both directions.
	task automatic test_policies();
		logic [POLICY_W-1:0] pols [4] = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED};
		logic [AMOUNT_W-1:0] sizes [4] = '{16'd300, 16'd100, 16'd300, 16'd100};
		write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(4));
		foreach (pols[p]) begin
			write_reg(REG_POLICY, CFG_DATA_W'(pols[p]));
			// Reloading also frees partitions that were taken before.
			foreach (sizes[i])
				send_word(ACT_LOAD, SLOT_W'(i), sizes[i]);
			send_word(ACT_ALLOC, '0, 16'd100);
			send_word(ACT_ALLOC, '0, 16'd300);
			send_word(ACT_ALLOC, '0, 16'd301);
			settle_idle();
		end
	endtask

	// Zero, one and an oversized partition count.
	task automatic test_count_edges();
		write_reg(REG_POLICY, CFG_DATA_W'(POL_FIRST));
		write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(0));
		send_word(ACT_ALLOC, '0, '0);
		settle_idle();
		write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(1));
		send_word(ACT_LOAD, '0, '1);
		send_word(ACT_ALLOC, '0, '1);
		send_word(ACT_ALLOC, '0, '0);
		settle_idle();
		write_reg(REG_BLOCK_COUNT, '1);
		send_word(ACT_ALLOC, '0, '0);
		send_word(ACT_ALLOC, '0, '1);
		settle_idle();
	endtask

	// Phases of mixed loads and allocates, each under new register settings.
	task automatic test_random_traffic();
		logic [POLICY_W-1:0] pol;
		logic [BCOUNT_W-1:0] cnt;
		logic [AMOUNT_W-1:0] mask;
		logic [AMOUNT_W-1:0] amt;
		logic [SLOT_W-1:0]   slot;
		int                  lim;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm = (ph == RANDOM_PHASES - 1);
			pol = POLICY_W'($urandom_range(0, 3));
			case ($urandom_range(0, 5))
				0: cnt = BCOUNT_W'($urandom_range(0, 63));
				1: cnt = BCOUNT_W'(MAX_PARTITIONS_DEF);
				2: cnt = '1;
				default: cnt = BCOUNT_W'($urandom_range(1, 12));
			endcase
			// Upper data bits of a policy write are don't-care; drive them anyway.
			write_reg(REG_POLICY, {(CFG_DATA_W-POLICY_W)'($urandom_range(0, 15)), pol});
			write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(cnt));
			lim = (cnt > MAX_PARTITIONS_DEF) ? MAX_PARTITIONS_DEF : cnt;
			// Keep sizes and requests on one scale so both grants and denials occur.
			mask = AMOUNT_W'((32'd1 << $urandom_range(4, 16)) - 1);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				amt = AMOUNT_W'($urandom) & mask;
				case ($urandom_range(0, 15))
					0: amt = '0;
					1: amt = '1;
					default: ;
				endcase
				if ($urandom_range(0, 99) < 45) begin
					if (lim > 0 && $urandom_range(0, 7) != 0)
						slot = SLOT_W'($urandom_range(0, lim - 1));
					else
						slot = SLOT_W'($urandom_range(0, MAX_PARTITIONS_DEF - 1));
					send_word(ACT_LOAD, slot, amt);
				end else begin
					if ($urandom_range(0, 1))
						amt = amt >> $urandom_range(0, 3);
					send_word(ACT_ALLOC, SLOT_W'($urandom), amt);
				end
			end
			settle_idle();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_LOAD;
		req_ch.slot = '0;
		req_ch.amount = '0;
		rsp_ch.ready = 1'b0;
		ready_hold = 0;
		calm = 0;
		mismatches = 0;
		quiet_cycles = 0;
		cur_policy = POLICY_RST;
		cur_count = BCOUNT_RST;
		foreach (part_size[i]) begin
			part_size[i] = '0;
			part_used[i] = 0;
		end

		// Single reset at the start of the run.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_policies();
		test_count_edges();
		test_random_traffic();

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_in_if.sv
rtl/fpa_out_if.sv
rtl/fpa_ram.sv
rtl/fixed_partition_allocator_unit.sv
sim/tb_top.sv
